### rtl/core/tabulated_inverse_cdf_sampler_assert.svh
// assertion macros for the tabulated inverse cdf sampler
// depends on nothing; included by the top level only
`ifndef TABULATED_INVERSE_CDF_SAMPLER_ASSERT_SVH
`define TABULATED_INVERSE_CDF_SAMPLER_ASSERT_SVH

// same-cycle implication
`define TICS_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TICS_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tics_pkg.sv
// shared types, codes and saturation helper for the sampler
// no dependencies
`timescale 1ns / 1ps

package tics_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int X_BITS         = 32;
  localparam int WEIGHT_BITS    = 16;
  localparam int U_BITS         = 32;
  localparam int STATUS_BITS    = 2;
  localparam int SAT_IN_W       = X_BITS + 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FEW  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_ZERO = 2'd2;

  typedef struct packed {
    logic                      command;
    logic                      first_point;
    logic signed [X_BITS-1:0]  point_x;
    logic [WEIGHT_BITS-1:0]    point_weight;
    logic [U_BITS-1:0]         uniform_draw;
  } cmd_t;

  typedef struct packed {
    logic signed [X_BITS-1:0]  sample_x;
    logic [STATUS_BITS-1:0]    status;
  } res_t;

  // clamp a wide signed value into the x range
  function automatic logic signed [X_BITS-1:0] sat_x(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] lim_hi;
    logic signed [SAT_IN_W-1:0] lim_lo;
    lim_hi = {{(SAT_IN_W-X_BITS+1){1'b0}}, {(X_BITS-1){1'b1}}};
    lim_lo = ~lim_hi;
    if (v > lim_hi) begin
      return {1'b0, {(X_BITS-1){1'b1}}};
    end else if (v < lim_lo) begin
      return {1'b1, {(X_BITS-1){1'b0}}};
    end
    return v[X_BITS-1:0];
  endfunction

endpackage

### rtl/core/tics_mem.sv
// point and cumulative weight memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tics_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 58,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tics_div.sv
// restoring divider, one quotient bit per cycle
// expects num < den * 2^Q_W so the quotient fits Q_W bits
`timescale 1ns / 1ps

module tics_div #(
  parameter int CUM_W = 26,
  parameter int Q_W   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [CUM_W+Q_W-1:0]   num,
  input  logic [CUM_W-1:0]       den,
  output logic                   done,
  output logic [Q_W-1:0]         quot
);

  localparam int SW = $clog2(Q_W + 1);

  logic [CUM_W-1:0] rem;
  logic [CUM_W-1:0] den_r;
  logic [Q_W-1:0]   shf;
  logic [SW-1:0]    steps;
  logic             run;
  logic [CUM_W:0]   trial;
  logic [CUM_W:0]   trial_sub;
  logic             take;

  // dividend bits shift out the top while quotient bits shift in
  assign trial     = {rem, shf[Q_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign take      = (trial >= {1'b0, den_r});
  assign quot      = shf;

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        steps <= SW'(Q_W);
      end else if (run) begin
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= num[CUM_W+Q_W-1:Q_W];
      shf   <= num[Q_W-1:0];
      den_r <= den;
    end else if (run) begin
      rem <= take ? trial_sub[CUM_W-1:0] : trial[CUM_W-1:0];
      shf <= {shf[Q_W-2:0], take};
    end
  end

endmodule

### rtl/core/tics_scale.sv
// byte-serial signed x unsigned fraction product, floor(diff * frac / 2^FW)
// no dependencies
`timescale 1ns / 1ps

module tics_scale #(
  parameter int DW = 34,
  parameter int FW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [DW-1:0] diff,
  input  logic [FW-1:0]        frac,
  output logic                 done,
  output logic signed [DW-1:0] acc_out
);

  localparam int STEPS = FW / 8;
  localparam int SW    = $clog2(STEPS + 1);
  localparam int AW    = DW + 9;

  logic signed [DW-1:0] diff_r;
  logic [FW-1:0]        frac_r;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] sum;
  logic [SW-1:0]        steps;
  logic                 run;

  // low byte first; the shift after each byte keeps the floor exact
  assign prod    = diff_r * $signed({1'b0, frac_r[7:0]});
  assign sum     = acc + prod;
  assign acc_out = acc[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        steps <= SW'(STEPS);
      end else if (run) begin
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      diff_r <= diff;
      frac_r <= frac;
      acc    <= '0;
    end else if (run) begin
      acc    <= sum >>> 8;
      frac_r <= frac_r >> 8;
    end
  end

endmodule

### rtl/core/tabulated_inverse_cdf_sampler.sv
// top level: command decode, table loading, binary search and result register
// depends on tics_pkg, tics_mem, tics_div, tics_scale and the assertion header
`timescale 1ns / 1ps
`include "tabulated_inverse_cdf_sampler_assert.svh"

// Tabulated inverse-cdf sampler. Load transfers append one point (Q16.16 x and a
// weight) and are finished at the edge that accepts them, so busy stays low and a
// load can follow another load in the next cycle. A draw transfer with fewer than
// two points or zero total weight answers in the next cycle with an error status.
// Any other draw works through these steps: each binary-search probe is a read
// of the table memory plus a compare, then a restoring divider builds the
// interpolation fraction and a byte-serial multiplier scales the edge gap. A
// probe that hits a cumulative weight exactly ends the draw early. busy is high
// while a draw works. The result is on the result port for exactly one cycle,
// marked by done; the receiver cannot stall it, so it must take every transfer
// as it comes.
module tabulated_inverse_cdf_sampler #(
  parameter int MAX_POINTS = tics_pkg::MAX_POINTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tics_pkg::cmd_t  item,
  output logic            busy,
  output logic            done,
  output tics_pkg::res_t  result
);

  localparam int XB    = tics_pkg::X_BITS;
  localparam int UB    = tics_pkg::U_BITS;
  localparam int SIW   = tics_pkg::SAT_IN_W;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int CUM_W = tics_pkg::WEIGHT_BITS + AW;
  localparam int Y_W   = UB + CUM_W;
  localparam int EW    = XB + 1;
  localparam int DW    = XB + 2;
  localparam int MW    = XB + CUM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;

  // control state
  logic [2:0]            state;
  logic [CW-1:0]         count;
  logic [CUM_W-1:0]      total;
  logic signed [XB-1:0]  spacing;

  // payload state
  logic signed [XB-1:0]  x_first;
  logic signed [XB-1:0]  x_last;
  logic [Y_W-1:0]        y;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [CW-1:0]         mid;
  logic [CUM_W-1:0]      cum_lo;
  logic [CUM_W-1:0]      cum_hi;
  logic signed [XB-1:0]  x_lo;
  logic signed [XB-1:0]  x_hi;
  logic signed [EW-1:0]  edge_lo;
  logic signed [DW-1:0]  diff;

  // handshake and load datapath
  logic                  accept;
  logic                  is_load;
  logic                  is_draw;
  logic [CW-1:0]         eff_count;
  logic [CUM_W-1:0]      eff_total;
  logic [CUM_W-1:0]      new_total;
  logic                  load_ok;
  logic signed [XB-1:0]  span;

  // search datapath
  logic signed [XB-1:0]  half;
  logic [CW-1:0]         gap;
  logic                  searching;
  logic [CW:0]           mid_sum;
  logic [CW-1:0]         mid_c;
  logic [CW-1:0]         mid_m1;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [MW-1:0]         wdata;
  logic [AW-1:0]         raddr;
  logic [MW-1:0]         rdata;
  logic [CUM_W-1:0]      rd_cum;
  logic signed [XB-1:0]  rd_x;
  logic [Y_W-1:0]        y_probe;
  logic signed [XB-1:0]  hit_x;
  logic signed [EW-1:0]  edge_lo_c;
  logic signed [EW-1:0]  edge_hi_c;
  logic signed [DW-1:0]  diff_c;

  // interpolation units
  logic                  div_go;
  logic [Y_W-1:0]        div_num;
  logic [CUM_W-1:0]      div_den;
  logic                  div_done;
  logic [UB-1:0]         frac;
  logic                  scl_go;
  logic                  scl_done;
  logic signed [DW-1:0]  scl_acc;
  logic signed [XB-1:0]  interp_x;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign is_load = accept && (item.command == tics_pkg::CMD_LOAD);
  assign is_draw = accept && (item.command == tics_pkg::CMD_DRAW);

  // first_point restarts the table before this point goes in
  assign eff_count = item.first_point ? '0 : count;
  assign eff_total = item.first_point ? '0 : total;
  assign new_total = eff_total + CUM_W'(item.point_weight);
  assign load_ok   = (eff_count < CW'(MAX_POINTS));
  assign span      = tics_pkg::sat_x(SIW'(item.point_x) - SIW'(x_first));

  // memory row k holds point k and the cumulative weight through point k,
  // i.e. cumulative entry k+1; cumulative entry 0 is the constant zero
  assign we    = is_load && load_ok;
  assign waddr = eff_count[AW-1:0];
  assign wdata = {item.point_x, new_total};

  assign half      = spacing >>> 1;
  assign gap       = hi - lo;
  assign searching = (gap > CW'(1));
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_c     = mid_sum[CW:1];
  assign mid_m1    = mid_c - CW'(1);
  assign raddr     = mid_m1[AW-1:0];

  assign rd_cum  = rdata[CUM_W-1:0];
  assign rd_x    = $signed(rdata[MW-1:CUM_W]);
  assign y_probe = {rd_cum, {UB{1'b0}}};
  assign hit_x   = tics_pkg::sat_x(SIW'(rd_x) + SIW'(half));

  // left edge of bin 0 sits half a spacing below the first point
  assign edge_lo_c = (lo == '0) ? (EW'(x_lo) - EW'(half)) : (EW'(x_lo) + EW'(half));
  assign edge_hi_c = EW'(x_hi) + EW'(half);
  assign diff_c    = DW'(edge_hi_c) - DW'(edge_lo_c);

  // bracket is settled: fraction = (y - C[lo]*2^32) / (C[hi] - C[lo])
  assign div_go  = (state == S_PROBE) && !searching;
  assign div_num = y - {cum_lo, {UB{1'b0}}};
  assign div_den = cum_hi - cum_lo;
  assign scl_go  = (state == S_DIV) && div_done;

  assign interp_x = tics_pkg::sat_x(SIW'(edge_lo) + SIW'(scl_acc));

  tics_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (MW),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tics_div #(
    .CUM_W (CUM_W),
    .Q_W   (UB)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (frac)
  );

  tics_scale #(
    .DW (DW),
    .FW (UB)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .go      (scl_go),
    .diff    (diff),
    .frac    (frac),
    .done    (scl_done),
    .acc_out (scl_acc)
  );

  // control: sequencer, table bookkeeping, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      total   <= '0;
      spacing <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (we) begin
            count <= eff_count + CW'(1);
            total <= new_total;
            if (eff_count == CW'(1)) begin
              spacing <= span;
            end
          end
          if (is_draw) begin
            if (count < CW'(2) || total == '0) begin
              done <= 1'b1;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          state <= searching ? S_CMP : S_DIV;
        end
        S_CMP: begin
          if (y == y_probe) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_PROBE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (scl_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: search bracket, edges and the result register
  always_ff @(posedge clk) begin
    if (we) begin
      x_last <= item.point_x;
      if (eff_count == '0) begin
        x_first <= item.point_x;
      end
    end
    if (is_draw) begin
      // search starts with the whole table: lo = 0, hi = n
      y      <= item.uniform_draw * total;
      lo     <= '0;
      hi     <= count;
      cum_lo <= '0;
      cum_hi <= total;
      x_lo   <= x_first;
      x_hi   <= x_last;
      result.sample_x <= '0;
      result.status   <= (count < CW'(2)) ? tics_pkg::STATUS_FEW : tics_pkg::STATUS_ZERO;
    end
    if (state == S_PROBE) begin
      mid     <= mid_c;
      edge_lo <= edge_lo_c;
      diff    <= diff_c;
    end
    if (state == S_CMP) begin
      if (y > y_probe) begin
        lo     <= mid;
        cum_lo <= rd_cum;
        x_lo   <= rd_x;
      end else if (y < y_probe) begin
        hi     <= mid;
        cum_hi <= rd_cum;
        x_hi   <= rd_x;
      end else begin
        // exact hit returns the edge itself
        result.sample_x <= hit_x;
        result.status   <= tics_pkg::STATUS_OK;
      end
    end
    if (state == S_MUL && scl_done) begin
      result.sample_x <= interp_x;
      result.status   <= tics_pkg::STATUS_OK;
    end
  end

  `TICS_ASSERT_NEXT(a_draw_answers, clk, rst, is_draw, done || busy, "draw neither answered nor started")
  `TICS_ASSERT_NOW(a_err_zero, clk, rst, done && (result.status != tics_pkg::STATUS_OK), result.sample_x == '0, "error result carries a nonzero sample")
  `TICS_ASSERT_NOW(a_mid_inside, clk, rst, state == S_CMP, (lo < mid) && (mid < hi), "probe outside the search bracket")
  `TICS_ASSERT_NOW(a_bracket_order, clk, rst, state == S_PROBE, cum_lo < cum_hi, "bracket weights out of order")

endmodule
